[rtl/ffp_pkg.sv]
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types, codes and the 60 Hz cadence table for the frame pacer.
// ----------------------------------------------------------------------------
package ffp_pkg;

  // Field widths
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;  // now_ms, stop
  localparam int unsigned OUT_TDATA_W = 24;  // due, fire, period_used, resynced

  // Backlog limit as a shift: 32 periods
  localparam int unsigned BACKLOG_SHIFT = 5;

  // Command carried in tuser
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_MS       = 2'd0,
    REG_FRACTIONAL_ENABLE = 2'd1
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [PERIOD_W-1:0] INTERVAL_RST = 16'd17;
  localparam logic                FRAC_RST     = 1'b1;

  // Cadence phase codes
  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;

  // 16, 17, 17 ms cadence; the unused code repeats the first entry
  function automatic logic [PERIOD_W-1:0] cadence_ms(input logic [PHASE_W-1:0] ph);
    logic [PERIOD_W-1:0] ms;
    case (ph)
      PHASE_SECOND: ms = 16'd17;
      PHASE_THIRD:  ms = 16'd17;
      default:      ms = 16'd16;
    endcase
    return ms;
  endfunction

  // Advance the phase modulo 3
  function automatic logic [PHASE_W-1:0] phase_step(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] nx;
    case (ph)
      PHASE_FIRST:  nx = PHASE_SECOND;
      PHASE_SECOND: nx = PHASE_THIRD;
      PHASE_THIRD:  nx = PHASE_FIRST;
      default:      nx = PHASE_SECOND;
    endcase
    return nx;
  endfunction

  // Result word
  typedef struct packed {
    logic                resynced;
    logic [PERIOD_W-1:0] period_used;
    logic                fire;
    logic                due;
  } result_t;

endpackage

[rtl/fractional_frame_pacer_top.sv]
// ----------------------------------------------------------------------------
// fractional_frame_pacer_top
// Frame pacer against a free-running millisecond timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one word per command. tuser selects start
//   (latch now_ms as the frame base, clear the cadence phase) or poll
//   (check whether the current frame period has elapsed). Each word yields
//   exactly one result word with due, fire, period_used and resynced.
//   The period is the 16/17/17 ms cadence when fractional mode is set,
//   otherwise the interval register with zero taken as one ms.
//   The result register loads on the accept edge. Throughput is one word per
//   cycle while the output is not stalled; the base and phase registers update
//   on the same edge, so the following word sees them at once. The path is
//   two chained 32-bit subtracts feeding the signed compares and the base update.
//   A stalled result holds in the output register; in_tready stays high as
//   long as that register is empty or being drained this cycle.
//   The configuration port is always ready; write it only while no word is
//   in flight. Reset clears the base to zero, the phase to the first
//   cadence entry, the interval to 17 ms and selects fractional mode.
// ----------------------------------------------------------------------------
module fractional_frame_pacer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ffp_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] now_ms, [32] stop
  input  logic                               in_tuser,   // [0] command
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ffp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] due, [1] fire,
                                                         // [17:2] period_used, [18] resynced
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Registers
  logic [ffp_pkg::PERIOD_W-1:0] interval_r;
  logic                         frac_r;
  logic [ffp_pkg::NOW_W-1:0]    base_r, base_nxt;
  logic [ffp_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  ffp_pkg::result_t             res_r, res_nxt;
  logic                         out_valid_r;

  // Datapath signals
  logic                         in_fire;
  ffp_pkg::cmd_t                cmd;
  logic [ffp_pkg::NOW_W-1:0]    now_ms;
  logic                         stop;
  logic [ffp_pkg::PHASE_W-1:0]  phase_sel;
  logic [ffp_pkg::PERIOD_W-1:0] period;
  logic [ffp_pkg::NOW_W-1:0]    period_ext;
  logic [ffp_pkg::NOW_W-1:0]    backlog_lim;
  logic [ffp_pkg::NOW_W-1:0]    diff;
  logic [ffp_pkg::NOW_W-1:0]    lag;
  logic                         is_due;
  logic                         is_resync;

  // Unpack the input word
  assign cmd    = ffp_pkg::cmd_t'(in_tuser);
  assign now_ms = in_tdata[ffp_pkg::NOW_W-1:0];
  assign stop   = in_tdata[ffp_pkg::NOW_W];

  // Handshakes
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Select the period for this word; a start clears the phase first
  assign phase_sel = (cmd == ffp_pkg::CMD_START) ? ffp_pkg::PHASE_FIRST : phase_r;

  always_comb begin
    if (frac_r) begin
      period = ffp_pkg::cadence_ms(phase_sel);
    end else if (interval_r == '0) begin
      period = ffp_pkg::PERIOD_W'(1);
    end else begin
      period = interval_r;
    end
  end

  assign period_ext  = {{(ffp_pkg::NOW_W-ffp_pkg::PERIOD_W){1'b0}}, period};
  assign backlog_lim = period_ext << ffp_pkg::BACKLOG_SHIFT;

  // Elapsed time and the lag left after consuming one frame
  assign diff = now_ms - base_r;
  assign lag  = diff - period_ext;

  assign is_due    = !($signed(diff) < $signed(period_ext));
  assign is_resync = $signed(backlog_lim) < $signed(lag);

  // Next state and result
  always_comb begin
    base_nxt  = base_r;
    phase_nxt = phase_r;
    res_nxt.due         = 1'b0;
    res_nxt.fire        = 1'b0;
    res_nxt.resynced    = 1'b0;
    res_nxt.period_used = period;
    if (cmd == ffp_pkg::CMD_START) begin
      base_nxt  = now_ms;
      phase_nxt = ffp_pkg::PHASE_FIRST;
    end else if (is_due) begin
      res_nxt.due  = 1'b1;
      res_nxt.fire = !stop;
      phase_nxt    = ffp_pkg::phase_step(phase_r);
      if (is_resync) begin
        base_nxt         = now_ms - period_ext;
        res_nxt.resynced = 1'b1;
      end else begin
        base_nxt = base_r + period_ext;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= ffp_pkg::INTERVAL_RST;
      frac_r     <= ffp_pkg::FRAC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffp_pkg::REG_INTERVAL_MS:       interval_r <= cfg_data;
        ffp_pkg::REG_FRACTIONAL_ENABLE: frac_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pacer state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      phase_r     <= ffp_pkg::PHASE_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        base_r      <= base_nxt;
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ffp_pkg::OUT_TDATA_W-$bits(ffp_pkg::result_t)){1'b0}}, res_r};

  // Checks
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("cadence phase left its range");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == ffp_pkg::CMD_START) |=>
      (phase_r == ffp_pkg::PHASE_FIRST && !res_r.due && !res_r.resynced))
    else $error("start word did not clear phase or flags");

  a_fire_needs_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!res_r.fire && !res_r.resynced) || res_r.due))
    else $error("fire or resync without a due frame");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.period_used != '0))
    else $error("zero period reported");

endmodule

[tb/tb_fractional_frame_pacer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_frame_pacer_top
// Self-checking bench for the frame pacer.
// A queue of start and poll words feeds a clocked stream driver. Every word
// accepted goes through a local pacing model that keeps its own base time,
// cadence phase and register copies, and queues the result it should give.
// A clocked monitor drains the result stream with random back-pressure and
// checks each word against the oldest queued result. Registers are changed
// only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_fractional_frame_pacer_top;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    ffp_pkg::cmd_t cmd;
    logic [31:0]   now;
    logic          stop;
  } pace_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ffp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ffp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ffp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ffp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  fractional_frame_pacer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state and register copies
  logic [31:0]                  base_q     = '0;
  logic [ffp_pkg::PHASE_W-1:0]  phase_q    = ffp_pkg::PHASE_FIRST;
  logic [ffp_pkg::PERIOD_W-1:0] interval_q = ffp_pkg::INTERVAL_RST;
  logic                         frac_q     = ffp_pkg::FRAC_RST;

  pace_cmd_t          pending_cmds[$];
  ffp_pkg::result_t   expected_frames[$];
  pace_cmd_t          offered_cmd;

  int unsigned errors = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg = 0;
  int unsigned n_resync = 0;
  int unsigned n_fire = 0;
  int unsigned idle_cycles = 0;

  // Pacing knobs, changed by the sequencer between edges
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_done = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Frame length for a cadence position under the current registers
  function automatic logic [ffp_pkg::PERIOD_W-1:0] frame_len(
      input logic [ffp_pkg::PHASE_W-1:0] ph);
    logic [ffp_pkg::PERIOD_W-1:0] cadence [3];
    cadence = '{16'd16, 16'd17, 16'd17};
    if (frac_q) return cadence[2'(ph % 3)];
    if (interval_q == '0) return 16'd1;
    return interval_q;
  endfunction

  // Advance the model by one accepted word and queue its result
  task automatic pace_frame(input pace_cmd_t c);
    ffp_pkg::result_t             r;
    logic [31:0]                  lag;
    logic [ffp_pkg::PERIOD_W-1:0] per;
    r = '0;
    if (c.cmd == ffp_pkg::CMD_START) begin
      base_q  = c.now;
      phase_q = ffp_pkg::PHASE_FIRST;
      r.period_used = frame_len(phase_q);
    end else begin
      per = frame_len(phase_q);
      r.period_used = per;
      lag = c.now - base_q;
      if ($signed(lag) >= $signed({16'd0, per})) begin
        r.due = 1'b1;
        base_q = base_q + per;
        lag = c.now - base_q;
        // drop the backlog once more than 32 frames behind
        if ($signed(lag) > $signed({11'd0, per, 5'd0})) begin
          base_q = c.now - per;
          r.resynced = 1'b1;
          n_resync++;
        end
        r.fire = !c.stop;
        if (r.fire) n_fire++;
        phase_q = 2'((phase_q + 2'd1) % 3);
      end
    end
    expected_frames.push_back(r);
  endtask

  // Stream driver: hold the word until taken, then insert a gap or the next word
  always @(posedge clk) begin : drive_p
    pace_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pace_frame(offered_cmd);
        n_words++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          offered_cmd = c;
          in_tvalid <= 1'b1;
          in_tuser  <= c.cmd;
          in_tdata  <= {{(ffp_pkg::IN_TDATA_W-ffp_pkg::NOW_W-1){1'b0}}, c.stop, c.now};
          if (tx_idle_on) tx_gap = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each word, then pick the next ready level
  always @(posedge clk) begin : watch_p
    ffp_pkg::result_t got;
    ffp_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = ffp_pkg::result_t'(out_tdata[$bits(ffp_pkg::result_t)-1:0]);
        n_results++;
        if (expected_frames.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] unexpected result word %h", $realtime, got);
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("[%0t] result %0d: exp due=%0b fire=%0b period=%0d resync=%0b",
                       $realtime, n_results, want.due, want.fire, want.period_used,
                       want.resynced);
              $display("    got due=%0b fire=%0b period=%0d resync=%0b",
                       got.due, got.fire, got.period_used, got.resynced);
            end
          end
        end
        if (rx_idle_on) rx_gap = idle_len();
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (hold_done < hold_req) begin
        // long hold-off so the output register fills and the input stalls
        hold_done++;
        rx_hold = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_cmd(input ffp_pkg::cmd_t cmd, input logic [31:0] now,
                          input logic stop);
    pace_cmd_t c;
    c.cmd  = cmd;
    c.now  = now;
    c.stop = stop;
    pending_cmds.push_back(c);
  endtask

  // Register write; the model copy changes on the accepting edge
  task automatic write_reg(input ffp_pkg::cfg_reg_t idx,
                           input logic [ffp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ffp_pkg::REG_INTERVAL_MS) interval_q = val;
    else frac_q = val[0];
    n_cfg++;
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_origin(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 32'hFFFF_FFFF - $urandom_range(0, span * 8);
    if (r == 1) return 32'h7FFF_FFFF - $urandom_range(0, span * 8);
    return $urandom();
  endfunction

  // Start followed by a stream of polls with mostly forward-moving time,
  // plus big leaps, steps back in time, restarts and fully random stamps
  task automatic gen_runs(input int n, input int unsigned span);
    logic [31:0] t;
    int unsigned r;
    @(negedge clk);
    t = pick_origin(span);
    push_cmd(ffp_pkg::CMD_START, t, 1'($urandom_range(0, 1)));
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        t = pick_origin(span);
        push_cmd(ffp_pkg::CMD_START, t, 1'($urandom_range(0, 1)));
      end else begin
        if (r < 75)      t = t + $urandom_range(0, 2 * span);
        else if (r < 85) t = t + span * $urandom_range(33, 90);
        else if (r < 93) t = t - $urandom_range(1, 4 * span);
        else             t = $urandom();
        push_cmd(ffp_pkg::CMD_POLL, t, $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    logic [ffp_pkg::CFG_DATA_W-1:0] iv;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset cadence, stop, time before base, wrap, backlog drop
    @(negedge clk);
    push_cmd(ffp_pkg::CMD_POLL,  32'd5, 1'b0);
    push_cmd(ffp_pkg::CMD_START, 32'd0, 1'b1);
    push_cmd(ffp_pkg::CMD_POLL,  32'd15, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd16, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd33, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd50, 1'b1);
    push_cmd(ffp_pkg::CMD_POLL,  32'hFFFF_FFFF, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'h7FFF_FFFF, 1'b0);
    push_cmd(ffp_pkg::CMD_START, 32'hFFFF_FFF8, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd8, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd9, 1'b1);
    wait_drained();

    // Directed: interval zero taken as one ms, backlog right at the limit
    write_reg(ffp_pkg::REG_FRACTIONAL_ENABLE, 16'd0);
    write_reg(ffp_pkg::REG_INTERVAL_MS, 16'd0);
    @(negedge clk);
    push_cmd(ffp_pkg::CMD_START, 32'd100, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd100, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd101, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd134, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd170, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd169, 1'b1);
    wait_drained();

    // Directed: widest interval
    write_reg(ffp_pkg::REG_INTERVAL_MS, 16'hFFFF);
    @(negedge clk);
    push_cmd(ffp_pkg::CMD_START, 32'd0, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd65534, 1'b0);
    push_cmd(ffp_pkg::CMD_POLL,  32'd65535, 1'b1);
    push_cmd(ffp_pkg::CMD_POLL,  32'd65535 * 42, 1'b0);
    wait_drained();

    // Random: 60 Hz cadence, with a long receiver hold-off mid-stream
    write_reg(ffp_pkg::REG_INTERVAL_MS, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(ffp_pkg::REG_FRACTIONAL_ENABLE, 16'd1);
    gen_runs(150, 17);
    @(negedge clk);
    hold_req++;
    wait_drained();

    // Random: small intervals, no idling on either side
    iv = 16'($urandom_range(1, 40));
    write_reg(ffp_pkg::REG_FRACTIONAL_ENABLE, 16'd0);
    write_reg(ffp_pkg::REG_INTERVAL_MS, iv);
    @(negedge clk);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    gen_runs(150, iv);
    wait_drained();

    // Random: zero interval
    write_reg(ffp_pkg::REG_INTERVAL_MS, 16'd0);
    @(negedge clk);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    gen_runs(100, 1);
    wait_drained();

    // Random: widest interval
    write_reg(ffp_pkg::REG_INTERVAL_MS, 16'hFFFF);
    gen_runs(80, 65535);
    wait_drained();

    // Random: arbitrary interval
    iv = 16'($urandom_range(1, 16'hFFFF));
    write_reg(ffp_pkg::REG_INTERVAL_MS, iv);
    gen_runs(70, iv);
    wait_drained();

    // Random: back to the cadence, sender steady while the receiver stalls
    write_reg(ffp_pkg::REG_FRACTIONAL_ENABLE, 16'd1);
    @(negedge clk);
    tx_idle_on = 1'b0;
    gen_runs(150, 17);
    @(negedge clk);
    hold_req++;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words, %0d results, %0d register writes", n_words, n_results, n_cfg);
    $display("cadence and interval modes: %0d frames fired, %0d backlog drops", n_fire,
             n_resync);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[fractional_frame_pacer_top.f]
rtl/ffp_pkg.sv
rtl/fractional_frame_pacer_top.sv
tb/tb_fractional_frame_pacer_top.sv
